>>> rtl/ffba_pkg.sv
// shared constants, codes and types of the first-fit block allocator
`default_nettype none
package ffba_pkg;

  // heap geometry
  localparam int MAX_BLOCKS   = 256;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ADDR_W       = 17;
  localparam int REQ_W        = 16;
  localparam int HEADER_BYTES = 8;
  localparam int HEAP_CAP     = 65536;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_HEAP_LIMIT = 1'b0;

  // result codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_LIMIT   = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_UNKNOWN = 2'd3
  } status_t;

  // request kinds
  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  // one write into the block table
  typedef struct packed {
    logic              size_we;
    logic              free_we;
    logic [IDX_W-1:0]  addr;
    logic [ADDR_W-1:0] size;
    logic              free;
  } tbl_wr_t;

  // operands of one scan step
  typedef struct packed {
    mode_t             mode;
    logic              free;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] total;
    logic [ADDR_W-1:0] addr;
  } step_in_t;

  // outcome of one scan step
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] base_next;
    logic [ADDR_W-1:0] user_addr;
  } step_out_t;

endpackage
`default_nettype wire

>>> rtl/ffba_table.sv
// block size and free flag memories with registered read
`default_nettype none
module ffba_table import ffba_pkg::*; (
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  rd_addr,
  input  wire tbl_wr_t           wr,
  output logic      [ADDR_W-1:0] rd_size,
  output logic                   rd_free
);

  logic [ADDR_W-1:0] size_mem [MAX_BLOCKS];
  logic              free_mem [MAX_BLOCKS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.size_we) begin
      size_mem[wr.addr] <= wr.size;
    end
    if (wr.free_we) begin
      free_mem[wr.addr] <= wr.free;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rd_size <= size_mem[rd_addr];
    rd_free <= free_mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> rtl/ffba_step.sv
// shared add and compare unit used once per visited block
`default_nettype none
module ffba_step import ffba_pkg::*; (
  input  wire step_in_t  op,
  output step_out_t      res
);

  logic [ADDR_W:0] user_wide;

  always_comb begin
    // user address of the block under test
    user_wide     = {1'b0, op.base} + (ADDR_W + 1)'(HEADER_BYTES);
    res.user_addr = user_wide[ADDR_W-1:0];
    // running block start
    res.base_next = op.base + op.size;
    // fit test or address match
    if (op.mode == MODE_ALLOC) begin
      res.hit = op.free && (op.size >= op.total);
    end else begin
      res.hit = (user_wide == {1'b0, op.addr});
    end
  end

endmodule
`default_nettype wire

>>> rtl/first_fit_block_allocator_top.sv
// top level of the first-fit block allocator: sequencer, registers, ports
//
// Input channel (in_valid / in_stall) carries one request beat: mode 0
// allocates request_bytes plus an 8-byte header, mode 1 releases the block
// whose user address equals release_address. Each request gives exactly one
// result beat on the output channel (out_valid / out_stall) with
// user_address and status.
// One request is in work at a time; in_stall is high from acceptance until
// the result is handed to the output register. A request walks the block
// table one entry per cycle through the registered memory read. It visits
// at most block_count entries, at most 256; a hit goes from the scan to
// S_FINISH, while a miss or append first passes S_RESOLVE, the decision
// state. The block goes back to idle as the result moves to the output
// register, and takes the next request from idle. The output register
// holds a result while out_stall is high and the next request may be
// taken then; its result waits in the sequencer until the output
// register frees up. Reset empties the block table (block count and heap
// top to zero) and sets heap_limit to 65536. heap_limit is written over
// the APB port at address 0; the user must write it only while the block
// is idle, the block itself does not enforce this. pready is always high.
`default_nettype none
module first_fit_block_allocator_top import ffba_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mode,
  input  wire logic [REQ_W-1:0]   request_bytes,
  input  wire logic [ADDR_W-1:0]  release_address,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [ADDR_W-1:0]  user_address,
  output logic      [1:0]         status
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_RESOLVE = 4'b0100,
    S_FINISH  = 4'b1000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] heap_limit;
  logic [CNT_W-1:0]  block_count;
  logic [ADDR_W-1:0] heap_used;
  mode_t             req_mode;
  logic [ADDR_W-1:0] req_total;
  logic [ADDR_W-1:0] req_addr;
  logic [ADDR_W-1:0] base;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;

  logic              in_take;
  logic              cfg_wr;
  logic              out_free;
  logic              last_entry;
  logic [ADDR_W-1:0] lim;
  logic [ADDR_W:0]   heap_top_wide;
  logic [ADDR_W:0]   user_top_wide;
  logic              over_limit;
  logic              table_full;
  logic [IDX_W-1:0]  rd_addr;
  logic [ADDR_W-1:0] rd_size;
  logic              rd_free;
  tbl_wr_t           tbl_wr;
  step_in_t          step_op;
  step_out_t         step_res;

  // handshakes
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HEAP_LIMIT) begin
      prdata = PDATA_W'(heap_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= ADDR_W'(HEAP_CAP);
    end else if (cfg_wr && (paddr[2] == REG_HEAP_LIMIT)) begin
      heap_limit <= pwdata[ADDR_W-1:0];
    end
  end

  // effective limit and append checks
  assign lim           = (heap_limit > ADDR_W'(HEAP_CAP)) ? ADDR_W'(HEAP_CAP) : heap_limit;
  assign heap_top_wide = {1'b0, heap_used} + {1'b0, req_total};
  assign user_top_wide = {1'b0, heap_used} + (ADDR_W + 1)'(HEADER_BYTES);
  assign over_limit    = heap_top_wide > {1'b0, lim};
  assign table_full    = (block_count == CNT_W'(MAX_BLOCKS));
  assign last_entry    = (({1'b0, idx} + CNT_W'(1)) == block_count);

  // memory read address runs one entry ahead of the compare
  assign rd_addr = (state == S_SCAN) ? (idx + IDX_W'(1)) : '0;

  ffba_table u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (tbl_wr),
    .rd_size (rd_size),
    .rd_free (rd_free)
  );

  // shared step unit
  always_comb begin
    step_op.mode  = req_mode;
    step_op.free  = rd_free;
    step_op.size  = rd_size;
    step_op.base  = base;
    step_op.total = req_total;
    step_op.addr  = req_addr;
  end

  ffba_step u_step (
    .op  (step_op),
    .res (step_res)
  );

  // table writes: reuse, release or append
  always_comb begin
    tbl_wr = '0;
    if (state == S_SCAN && step_res.hit) begin
      tbl_wr.free_we = 1'b1;
      tbl_wr.addr    = idx;
      tbl_wr.free    = (req_mode == MODE_RELEASE);
    end else if (state == S_RESOLVE && req_mode == MODE_ALLOC && !over_limit
                 && !table_full) begin
      tbl_wr.size_we = 1'b1;
      tbl_wr.free_we = 1'b1;
      tbl_wr.addr    = block_count[IDX_W-1:0];
      tbl_wr.size    = req_total;
      tbl_wr.free    = 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      block_count <= '0;
      heap_used   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            req_mode  <= mode_t'(mode);
            req_total <= ADDR_W'(request_bytes) + ADDR_W'(HEADER_BYTES);
            req_addr  <= release_address;
            base      <= '0;
            idx       <= '0;
            state     <= (block_count == '0) ? S_RESOLVE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (step_res.hit) begin
            res_addr   <= (req_mode == MODE_ALLOC) ? step_res.user_addr : req_addr;
            res_status <= STATUS_OK;
            state      <= S_FINISH;
          end else begin
            base <= step_res.base_next;
            idx  <= idx + IDX_W'(1);
            if (last_entry) begin
              state <= S_RESOLVE;
            end
          end
        end
        S_RESOLVE: begin
          priority if (req_mode == MODE_RELEASE) begin
            res_addr   <= '0;
            res_status <= STATUS_UNKNOWN;
          end else if (over_limit) begin
            res_addr   <= '0;
            res_status <= STATUS_LIMIT;
          end else if (table_full) begin
            res_addr   <= '0;
            res_status <= STATUS_FULL;
          end else begin
            res_addr    <= user_top_wide[ADDR_W-1:0];
            res_status  <= STATUS_OK;
            block_count <= block_count + CNT_W'(1);
            heap_used   <= heap_top_wide[ADDR_W-1:0];
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      user_address <= res_addr;
      status       <= res_status;
    end
  end

endmodule
`default_nettype wire

>>> sim/tb.sv
// testbench of the first-fit block allocator: shadow heap model, random and directed requests
module tb;
  import ffba_pkg::*;

  localparam int TRACK           = 0;    // shadow of the heap as the block has taken requests
  localparam int PLAN            = 1;    // shadow of the heap as queued requests will leave it
  localparam int IDLE_MAX        = 14;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int END_WAIT        = 300;
  localparam int RANDOM_PHASES   = 5;
  localparam int PHASE_ITEMS     = 130;
  localparam logic REG_SPARE     = 1'b1; // register index past the end of the map

  // one request beat and one result beat
  typedef struct packed {
    mode_t             op;
    logic [REQ_W-1:0]  nbytes;
    logic [ADDR_W-1:0] rel_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] uaddr;
    status_t           st;
  } resp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = 1'b0;
  logic [REQ_W-1:0]   request_bytes = '0;
  logic [ADDR_W-1:0]  release_address = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ADDR_W-1:0]  user_address;
  logic [1:0]         status;

  // shadow heap state, two copies
  logic [ADDR_W-1:0] shadow_size [2][MAX_BLOCKS];
  bit                shadow_free [2][MAX_BLOCKS];
  int                shadow_count [2];
  int                shadow_top [2];
  int                shadow_limit [2];

  req_t  pending_reqs[$];
  resp_t owed_results[$];

  bit req_taken = 1'b0;
  bit res_taken = 1'b0;
  int send_gap = 0;
  int res_wait = 0;
  int send_idle_max = IDLE_MAX;
  int recv_idle_max = IDLE_MAX;
  int hold_off_left = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;

  first_fit_block_allocator_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .request_bytes   (request_bytes),
    .release_address (release_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .user_address    (user_address),
    .status          (status)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // first-fit allocate or release on one shadow copy, returns the result beat
  function automatic resp_t first_fit_serve(input int c, input req_t r);
    resp_t res;
    int    total;
    int    base;
    int    lim;
    int    i;
    res.uaddr = '0;
    res.st = STATUS_OK;
    base = 0;
    total = int'(r.nbytes) + HEADER_BYTES;
    lim = (shadow_limit[c] > HEAP_CAP) ? HEAP_CAP : shadow_limit[c];
    if (r.op == MODE_ALLOC) begin
      // walk blocks in address order, take the first free one big enough
      for (i = 0; i < shadow_count[c]; i++) begin
        if (shadow_free[c][i] && int'(shadow_size[c][i]) >= total) begin
          shadow_free[c][i] = 1'b0;
          res.uaddr = ADDR_W'(base + HEADER_BYTES);
          return res;
        end
        base += int'(shadow_size[c][i]);
      end
      // append at heap top; limit is checked before table space
      if (shadow_top[c] + total > lim) begin
        res.st = STATUS_LIMIT;
      end else if (shadow_count[c] >= MAX_BLOCKS) begin
        res.st = STATUS_FULL;
      end else begin
        shadow_size[c][shadow_count[c]] = ADDR_W'(total);
        shadow_free[c][shadow_count[c]] = 1'b0;
        shadow_count[c]++;
        res.uaddr = ADDR_W'(shadow_top[c] + HEADER_BYTES);
        shadow_top[c] += total;
      end
    end else begin
      for (i = 0; i < shadow_count[c]; i++) begin
        if (base + HEADER_BYTES == int'(r.rel_addr)) begin
          shadow_free[c][i] = 1'b1;
          res.uaddr = r.rel_addr;
          return res;
        end
        base += int'(shadow_size[c][i]);
      end
      res.st = STATUS_UNKNOWN;
    end
    return res;
  endfunction

  // user address of block idx in a shadow copy
  function automatic int block_user_addr(input int c, input int idx);
    int base;
    int k;
    base = 0;
    for (k = 0; k < idx; k++) base += int'(shadow_size[c][k]);
    return base + HEADER_BYTES;
  endfunction

  // queue one request and advance the planning copy
  function automatic void plan_request(input mode_t op, input int nbytes, input int rel);
    req_t r;
    r.op = op;
    r.nbytes = REQ_W'(nbytes);
    r.rel_addr = ADDR_W'(rel);
    void'(first_fit_serve(PLAN, r));
    pending_reqs.push_back(r);
  endfunction

  // mostly allocations of small blocks and releases of real blocks, some noise
  function automatic void plan_random_request();
    int pick;
    int n;
    int size;
    int addr;
    pick = $urandom_range(0, 99);
    if (shadow_count[PLAN] == 0 || pick < 55) begin
      n = $urandom_range(0, 99);
      if (n < 3) size = $urandom_range(0, 65535);
      else if (n < 18) size = $urandom_range(0, 4000);
      else size = $urandom_range(0, 120);
      plan_request(MODE_ALLOC, size, $urandom_range(0, 65536));
    end else begin
      addr = block_user_addr(PLAN, $urandom_range(0, shadow_count[PLAN] - 1));
      // misaligned or random addresses for the unknown case
      if (pick >= 95) addr = $urandom_range(0, 65536);
      else if (pick >= 90) addr = addr + $urandom_range(1, 7);
      plan_request(MODE_RELEASE, $urandom_range(0, 65535), addr);
    end
  endfunction

  // register write over the apb port, block must be idle
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (addr[PADDR_W-1:2] == REG_HEAP_LIMIT) begin
      shadow_limit[TRACK] = int'(data[ADDR_W-1:0]);
      shadow_limit[PLAN]  = int'(data[ADDR_W-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait until every queued request has come back as a result
  task automatic wait_all_results();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || owed_results.size() != 0);
  endtask

  // request driver
  always @(negedge clk) begin
    req_t nxt;
    logic offer;
    if (!rst) begin
      offer = in_valid;
      if (req_taken) begin
        offer = 1'b0;
        req_taken = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          mode            <= nxt.op;
          request_bytes   <= nxt.nbytes;
          release_address <= nxt.rel_addr;
          send_gap = $urandom_range(0, send_idle_max);
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // result receiver stall, random per beat plus the long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (res_taken) begin
        res_taken = 1'b0;
        res_wait = $urandom_range(0, recv_idle_max);
      end
      out_stall <= (res_wait > 0) || (hold_off_left > 0);
      if (res_wait > 0) res_wait--;
    end
  end

  // long hold-off countdown
  always @(posedge clk) begin
    if (hold_off_left > 0) hold_off_left <= hold_off_left - 1;
  end

  // monitor: predict on each request beat, check each result beat
  always @(posedge clk) begin
    req_t  seen;
    resp_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen.op = mode_t'(mode);
        seen.nbytes = request_bytes;
        seen.rel_addr = release_address;
        owed_results.push_back(first_fit_serve(TRACK, seen));
        req_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        res_taken = 1'b1;
        if (owed_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result beat, expected none, actual user_address %0d status %0d",
                   $time, user_address, status);
        end else begin
          want = owed_results.pop_front();
          if (user_address !== want.uaddr) begin
            mismatch_count++;
            $display("%0t: user_address expected %0d, actual %0d", $time, want.uaddr, user_address);
          end
          if (status !== want.st) begin
            mismatch_count++;
            $display("%0t: status expected %0d, actual %0d", $time, want.st, status);
          end
        end
      end
    end
  end

  // watchdog: cycles with work outstanding but no beat moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (!in_valid && owed_results.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    int phase;
    int n;
    int guard;
    int max_free;
    int k;
    for (k = 0; k < 2; k++) begin
      shadow_count[k] = 0;
      shadow_top[k] = 0;
      shadow_limit[k] = HEAP_CAP;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // basics at the reset limit: zero-byte block, oversize, reuse, double and unknown release
    plan_request(MODE_ALLOC, 0, 0);
    plan_request(MODE_ALLOC, 65535, 65536);
    plan_request(MODE_ALLOC, 100, 0);
    plan_request(MODE_ALLOC, 40, 0);
    plan_request(MODE_RELEASE, 0, 16);
    plan_request(MODE_RELEASE, 65535, 16);
    plan_request(MODE_RELEASE, 0, 17);
    plan_request(MODE_RELEASE, 0, 0);
    plan_request(MODE_RELEASE, 0, 65536);
    plan_request(MODE_ALLOC, 50, 0);
    plan_request(MODE_RELEASE, 0, 8);
    plan_request(MODE_ALLOC, 0, 0);
    plan_request(MODE_RELEASE, 0, 124);
    plan_request(MODE_ALLOC, 41, 0);
    wait_all_results();

    // limit zero, below the heap top: reuse still works, appends fail
    write_reg({REG_HEAP_LIMIT, 2'b00}, '0);
    plan_request(MODE_RELEASE, 0, 16);
    plan_request(MODE_ALLOC, 30, 0);
    plan_request(MODE_ALLOC, 0, 0);
    plan_request(MODE_ALLOC, 0, 0);
    wait_all_results();

    // write past the register map is ignored
    write_reg({REG_SPARE, 2'b00}, 32'h0001_0000);
    plan_request(MODE_ALLOC, 0, 0);
    wait_all_results();

    // oversize limit saturates at the heap cap
    write_reg({REG_HEAP_LIMIT, 2'b00}, '1);
    plan_request(MODE_ALLOC, 0, 0);
    wait_all_results();

    // limit exactly at the heap top plus one block
    write_reg({REG_HEAP_LIMIT, 2'b00}, PDATA_W'(shadow_top[PLAN] + HEADER_BYTES + 20));
    plan_request(MODE_ALLOC, 20, 0);
    plan_request(MODE_ALLOC, 0, 0);
    wait_all_results();

    // random phases at several limits and idle patterns
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      send_idle_max = IDLE_MAX;
      recv_idle_max = IDLE_MAX;
      case (phase)
        0: write_reg({REG_HEAP_LIMIT, 2'b00}, PDATA_W'(HEAP_CAP));
        1: begin
          write_reg({REG_HEAP_LIMIT, 2'b00}, $urandom);
          @(posedge clk);
          hold_off_left <= HOLD_OFF_CYCLES;
        end
        2: begin
          write_reg({REG_HEAP_LIMIT, 2'b00},
                    PDATA_W'(shadow_top[PLAN] + $urandom_range(200, 3000)));
          send_idle_max = 0;
          recv_idle_max = 0;
        end
        3: write_reg({REG_HEAP_LIMIT, 2'b00}, PDATA_W'(17'h1FFFF));
        default: write_reg({REG_HEAP_LIMIT, 2'b00}, PDATA_W'(HEAP_CAP));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) plan_random_request();
      wait_all_results();
    end

    // fill the block table, then ask for more than any free block holds
    guard = 0;
    while (shadow_count[PLAN] < MAX_BLOCKS && guard < 2 * MAX_BLOCKS) begin
      plan_request(MODE_ALLOC, 0, 0);
      guard++;
    end
    max_free = 0;
    for (k = 0; k < shadow_count[PLAN]; k++) begin
      if (shadow_free[PLAN][k] && int'(shadow_size[PLAN][k]) > max_free)
        max_free = int'(shadow_size[PLAN][k]);
    end
    plan_request(MODE_ALLOC, (max_free > 65535) ? 65535 : max_free, 0);
    wait_all_results();

    // full table and zero limit together: limit reported first
    write_reg({REG_HEAP_LIMIT, 2'b00}, '0);
    plan_request(MODE_ALLOC, 65535, 0);
    plan_request(MODE_RELEASE, 0, HEADER_BYTES);
    plan_request(MODE_ALLOC, 0, 0);
    wait_all_results();

    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
